>>> rtl/pidlt_pkg.sv
package pidlt_pkg;

    // Configuration register indexes.
    typedef enum logic [3:0] {
        REG_BRIGHTNESS_TARGET = 4'd0,
        REG_SLOW_SPEED        = 4'd1,
        REG_FAST_SPEED        = 4'd2,
        REG_KP_SLOW           = 4'd3,
        REG_KD_SLOW           = 4'd4,
        REG_KP_FAST           = 4'd5,
        REG_KI_FAST           = 4'd6,
        REG_KD_FAST           = 4'd7
    } cfg_reg_t;

    localparam int CfgIndexW = 4;
    localparam int CfgDataW  = 14;
    localparam int GainW     = 14;
    localparam int SpeedW    = 7;

    // Register reset values.
    localparam logic [7:0]       RstTarget    = 8'd40;
    localparam logic [SpeedW-1:0] RstSlowSpeed = 7'd35;
    localparam logic [SpeedW-1:0] RstFastSpeed = 7'd70;
    localparam logic [GainW-1:0] RstKpSlow    = 14'd500;
    localparam logic [GainW-1:0] RstKdSlow    = 14'd2000;
    localparam logic [GainW-1:0] RstKpFast    = 14'd100;
    localparam logic [GainW-1:0] RstKiFast    = 14'd5;
    localparam logic [GainW-1:0] RstKdFast    = 14'd3000;

    // Distance thresholds of the mode schedule.
    localparam logic [11:0] LimitFastFirst  = 12'd2700;
    localparam logic [11:0] LimitFastSecond = 12'd1700;
    localparam logic [11:0] LimitFastThird  = 12'd550;
    localparam logic [8:0]  LimitSlowNormal = 9'd400;
    localparam logic [8:0]  LimitSlowFirst  = 9'd50;

    localparam logic signed [13:0] SumMax = 14'sd4095;
    localparam logic signed [13:0] SumMin = -14'sd4096;

    localparam logic signed [18:0] TurnMax  = 19'sd2047;
    localparam logic signed [18:0] TurnMin  = -19'sd2048;
    localparam logic signed [12:0] DriveMax = 13'sd2047;
    localparam logic signed [12:0] DriveMin = -13'sd2048;

    // ceil(2^37 / 1000): exact division by 1000 for dividends below 2^27.
    localparam int            RecipShift = 37;
    localparam logic [27:0]   Recip1000  = 28'd137438954;

    typedef struct packed {
        logic                err_neg;
        logic [7:0]          err_mag;
        logic                sum_neg;
        logic [12:0]         sum_mag;
        logic                diff_neg;
        logic [8:0]          diff_mag;
        logic [GainW-1:0]    kp;
        logic [GainW-1:0]    ki;
        logic [GainW-1:0]    kd;
        logic [SpeedW-1:0]   speed;
        logic                drive_valid;
        logic                encoder_reset;
        logic                done;
    } front_t;

    typedef struct packed {
        logic                err_neg;
        logic [21:0]         p_prod;
        logic                sum_neg;
        logic [26:0]         i_prod;
        logic                diff_neg;
        logic [22:0]         d_prod;
        logic [SpeedW-1:0]   speed;
        logic                drive_valid;
        logic                encoder_reset;
        logic                done;
    } prod_t;

    typedef struct packed {
        logic                err_neg;
        logic [12:0]         p_quo;
        logic                sum_neg;
        logic [16:0]         i_quo;
        logic                diff_neg;
        logic [13:0]         d_quo;
        logic [SpeedW-1:0]   speed;
        logic                drive_valid;
        logic                encoder_reset;
        logic                done;
    } quo_t;

    typedef struct packed {
        logic signed [11:0]  turn;
        logic [SpeedW-1:0]   speed;
        logic                drive_valid;
        logic                encoder_reset;
        logic                done;
    } turn_t;

endpackage

>>> rtl/pid_line_tracer_gain_schedule.sv
// PID line tracer with a distance driven slow/fast gain schedule.
//
// Input channel: brightness and distance, one beat per control tick, taken
// when in_valid is high and in_stall is low. Output channel: one beat per
// input beat carrying left_drive, right_drive, drive_valid, encoder_reset
// and done_res, taken when out_valid is high and out_stall is low.
// Configuration: cfg_valid/cfg_ready with a register index and data; the
// port is always ready, and indexes beyond the eight configuration registers
// are ignored. Write it only while no tick is in flight.
//
// A beat may enter in every cycle while in_stall is low; the mode,
// integral and last-error state is updated as the beat is taken, and
// the three gain products, the divide by 1000 (a reciprocal multiply)
// and the saturation follow in a 5-stage pipeline.
// A stall on the output holds the result register; bubbles in the pipe
// still fill, and in_stall rises only once every stage holds a beat.
// Reset returns the registers to their defaults, slow mode, empty integral
// and an empty pipeline.
module pid_line_tracer_gain_schedule
    import pidlt_pkg::*;
#(
    parameter int INTEGRAL_WINDOW = 20
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               brightness,
    input  logic signed [15:0]       distance,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [11:0]       left_drive,
    output logic signed [11:0]       right_drive,
    output logic                     drive_valid,
    output logic                     encoder_reset,
    output logic                     done_res,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexW-1:0]     cfg_index,
    input  logic [CfgDataW-1:0]      cfg_data
);

    localparam int WinW = $clog2(INTEGRAL_WINDOW + 1);

    // Configuration registers.
    logic [7:0]        target_reg;
    logic [SpeedW-1:0] slow_speed_reg, fast_speed_reg;
    logic [GainW-1:0]  kp_slow_reg, kd_slow_reg, kp_fast_reg, ki_fast_reg, kd_fast_reg;

    // Controller state.
    logic               fast_mode_reg, fast_mode_next;
    logic               finished_reg, finished_next;
    logic [2:0]         fast_entries_reg, fast_entries_next;
    logic [2:0]         slow_entries_reg, slow_entries_next;
    logic [11:0]        fast_limit_reg, fast_limit_next;
    logic [8:0]         slow_limit_reg, slow_limit_next;
    logic signed [12:0] error_sum_reg, error_sum_next;
    logic [WinW-1:0]    window_reg, window_next;
    logic signed [8:0]  last_error_reg, last_error_next;

    // Pipeline.
    logic   v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic   load1, load2, load3, load4, load5;
    logic   accept;
    front_t s1_reg, s1_next;
    prod_t  s2_reg, s2_next;
    quo_t   s3_reg, s3_next;
    turn_t  s4_reg, s4_next;
    logic signed [11:0] left_reg, left_next, right_reg, right_next;
    logic   drive_valid_reg, encoder_reset_reg, done_reg;

    // Front stage working values.
    logic signed [8:0]  err;
    logic signed [13:0] sum_wide;
    logic signed [12:0] sum_sat;
    logic signed [9:0]  diff;
    logic [WinW-1:0]    window_inc;
    logic [2:0]         fast_inc, slow_inc;
    logic               enc;

    // Divide stage products.
    logic [54:0] p_recip, i_recip, d_recip;

    // Turn and drive working values.
    logic signed [18:0] p_term, i_term, d_term, turn_sum;
    logic signed [12:0] left_wide, right_wide;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= RstTarget;
            slow_speed_reg <= RstSlowSpeed;
            fast_speed_reg <= RstFastSpeed;
            kp_slow_reg    <= RstKpSlow;
            kd_slow_reg    <= RstKdSlow;
            kp_fast_reg    <= RstKpFast;
            ki_fast_reg    <= RstKiFast;
            kd_fast_reg    <= RstKdFast;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BRIGHTNESS_TARGET: target_reg     <= cfg_data[7:0];
                REG_SLOW_SPEED:        slow_speed_reg <= cfg_data[SpeedW-1:0];
                REG_FAST_SPEED:        fast_speed_reg <= cfg_data[SpeedW-1:0];
                REG_KP_SLOW:           kp_slow_reg    <= cfg_data;
                REG_KD_SLOW:           kd_slow_reg    <= cfg_data;
                REG_KP_FAST:           kp_fast_reg    <= cfg_data;
                REG_KI_FAST:           ki_fast_reg    <= cfg_data;
                REG_KD_FAST:           kd_fast_reg    <= cfg_data;
                default:               ;
            endcase
        end
    end

    // A stage takes new data when it is empty or its own content moves on.
    assign load5    = !out_valid_reg || !out_stall;
    assign load4    = !v4_reg || load5;
    assign load3    = !v3_reg || load4;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign in_stall = !load1;
    assign accept   = in_valid && load1;

    // Front stage: error, integral, schedule and the state update.
    always_comb
    begin
        err      = $signed({1'b0, brightness}) - $signed({1'b0, target_reg});
        sum_wide = {error_sum_reg[12], error_sum_reg} + {{5{err[8]}}, err};
        if (sum_wide > SumMax)
            sum_sat = SumMax[12:0];
        else if (sum_wide < SumMin)
            sum_sat = SumMin[12:0];
        else
            sum_sat = sum_wide[12:0];
        diff = {err[8], err} - {last_error_reg[8], last_error_reg};

        window_inc = window_reg + 1'b1;
        if (window_inc >= WinW'(INTEGRAL_WINDOW))
        begin
            window_next    = '0;
            error_sum_next = '0;
        end
        else
        begin
            window_next    = window_inc;
            error_sum_next = sum_sat;
        end

        fast_inc = (fast_entries_reg < 3'd7) ? fast_entries_reg + 3'd1 : fast_entries_reg;
        slow_inc = (slow_entries_reg < 3'd7) ? slow_entries_reg + 3'd1 : slow_entries_reg;

        fast_mode_next    = fast_mode_reg;
        finished_next     = finished_reg;
        fast_entries_next = fast_entries_reg;
        slow_entries_next = slow_entries_reg;
        fast_limit_next   = fast_limit_reg;
        slow_limit_next   = slow_limit_reg;
        enc               = 1'b0;

        if (!fast_mode_reg)
        begin
            if (distance >= $signed({7'b0, slow_limit_reg}))
            begin
                enc               = 1'b1;
                fast_mode_next    = 1'b1;
                fast_entries_next = fast_inc;
                if (fast_entries_reg != fast_inc)
                begin
                    case (fast_inc)
                        3'd2:    fast_limit_next = LimitFastSecond;
                        3'd3:    fast_limit_next = LimitFastThird;
                        3'd4:    finished_next   = 1'b1;
                        default: ;
                    endcase
                end
            end
        end
        else if (distance >= $signed({4'b0, fast_limit_reg}))
        begin
            enc               = 1'b1;
            fast_mode_next    = 1'b0;
            slow_entries_next = slow_inc;
            slow_limit_next   = LimitSlowNormal;
            // The limit drops back only on the fourth entry itself.
            if (slow_inc == 3'd4 && slow_entries_reg != slow_inc)
                slow_limit_next = LimitSlowFirst;
        end

        s1_next.drive_valid   = !enc && !finished_next;
        s1_next.encoder_reset = enc;
        s1_next.done          = finished_next;
        last_error_next       = s1_next.drive_valid ? err : last_error_reg;

        s1_next.err_neg  = err[8];
        s1_next.err_mag  = err[8] ? 8'(-err) : err[7:0];
        s1_next.sum_neg  = sum_sat[12];
        s1_next.sum_mag  = sum_sat[12] ? 13'(-sum_sat) : 13'(sum_sat);
        s1_next.diff_neg = diff[9];
        s1_next.diff_mag = diff[9] ? 9'(-diff) : diff[8:0];
        s1_next.kp       = fast_mode_reg ? kp_fast_reg : kp_slow_reg;
        s1_next.ki       = fast_mode_reg ? ki_fast_reg : '0;
        s1_next.kd       = fast_mode_reg ? kd_fast_reg : kd_slow_reg;
        s1_next.speed    = fast_mode_reg ? fast_speed_reg : slow_speed_reg;
    end

    // Gain products on magnitudes.
    always_comb
    begin
        s2_next.err_neg       = s1_reg.err_neg;
        s2_next.sum_neg       = s1_reg.sum_neg;
        s2_next.diff_neg      = s1_reg.diff_neg;
        s2_next.p_prod        = s1_reg.kp * s1_reg.err_mag;
        s2_next.i_prod        = s1_reg.ki * s1_reg.sum_mag;
        s2_next.d_prod        = s1_reg.kd * s1_reg.diff_mag;
        s2_next.speed         = s1_reg.speed;
        s2_next.drive_valid   = s1_reg.drive_valid;
        s2_next.encoder_reset = s1_reg.encoder_reset;
        s2_next.done          = s1_reg.done;
    end

    // Divide by 1000 on magnitudes, which truncates toward zero.
    always_comb
    begin
        p_recip = {5'b0, s2_reg.p_prod} * {27'b0, Recip1000};
        i_recip = 55'(s2_reg.i_prod) * 55'(Recip1000);
        d_recip = {4'b0, s2_reg.d_prod} * {27'b0, Recip1000};
        s3_next.err_neg       = s2_reg.err_neg;
        s3_next.sum_neg       = s2_reg.sum_neg;
        s3_next.diff_neg      = s2_reg.diff_neg;
        s3_next.p_quo         = p_recip[RecipShift +: 13];
        s3_next.i_quo         = i_recip[RecipShift +: 17];
        s3_next.d_quo         = d_recip[RecipShift +: 14];
        s3_next.speed         = s2_reg.speed;
        s3_next.drive_valid   = s2_reg.drive_valid;
        s3_next.encoder_reset = s2_reg.encoder_reset;
        s3_next.done          = s2_reg.done;
    end

    // Signed turn term, saturated to the drive range.
    always_comb
    begin
        p_term = $signed({6'b0, s3_reg.p_quo});
        i_term = $signed({2'b0, s3_reg.i_quo});
        d_term = $signed({5'b0, s3_reg.d_quo});
        if (s3_reg.err_neg)
            p_term = -p_term;
        if (s3_reg.sum_neg)
            i_term = -i_term;
        if (s3_reg.diff_neg)
            d_term = -d_term;
        turn_sum = p_term + i_term + d_term;
        if (turn_sum > TurnMax)
            s4_next.turn = TurnMax[11:0];
        else if (turn_sum < TurnMin)
            s4_next.turn = TurnMin[11:0];
        else
            s4_next.turn = turn_sum[11:0];
        s4_next.speed         = s3_reg.speed;
        s4_next.drive_valid   = s3_reg.drive_valid;
        s4_next.encoder_reset = s3_reg.encoder_reset;
        s4_next.done          = s3_reg.done;
    end

    // Wheel drives; both read zero on a tick that applies no drive.
    always_comb
    begin
        left_wide  = $signed({6'b0, s4_reg.speed}) + {s4_reg.turn[11], s4_reg.turn};
        right_wide = $signed({6'b0, s4_reg.speed}) - {s4_reg.turn[11], s4_reg.turn};
        if (!s4_reg.drive_valid)
            left_next = '0;
        else if (left_wide > DriveMax)
            left_next = DriveMax[11:0];
        else if (left_wide < DriveMin)
            left_next = DriveMin[11:0];
        else
            left_next = left_wide[11:0];
        if (!s4_reg.drive_valid)
            right_next = '0;
        else if (right_wide > DriveMax)
            right_next = DriveMax[11:0];
        else if (right_wide < DriveMin)
            right_next = DriveMin[11:0];
        else
            right_next = right_wide[11:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_mode_reg    <= 1'b0;
            finished_reg     <= 1'b0;
            fast_entries_reg <= '0;
            slow_entries_reg <= '0;
            fast_limit_reg   <= LimitFastFirst;
            slow_limit_reg   <= LimitSlowFirst;
            error_sum_reg    <= '0;
            window_reg       <= '0;
            last_error_reg   <= '0;
        end
        else if (accept)
        begin
            fast_mode_reg    <= fast_mode_next;
            finished_reg     <= finished_next;
            fast_entries_reg <= fast_entries_next;
            slow_entries_reg <= slow_entries_next;
            fast_limit_reg   <= fast_limit_next;
            slow_limit_reg   <= slow_limit_next;
            error_sum_reg    <= error_sum_next;
            window_reg       <= window_next;
            last_error_reg   <= last_error_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load1)
                v1_reg <= in_valid;
            if (load2)
                v2_reg <= v1_reg;
            if (load3)
                v3_reg <= v2_reg;
            if (load4)
                v4_reg <= v3_reg;
            if (load5)
                out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
            s1_reg <= s1_next;
        if (load2)
            s2_reg <= s2_next;
        if (load3)
            s3_reg <= s3_next;
        if (load4)
            s4_reg <= s4_next;
        if (load5)
        begin
            left_reg          <= left_next;
            right_reg         <= right_next;
            drive_valid_reg   <= s4_reg.drive_valid;
            encoder_reset_reg <= s4_reg.encoder_reset;
            done_reg          <= s4_reg.done;
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_drive    = left_reg;
    assign right_drive   = right_reg;
    assign drive_valid   = drive_valid_reg;
    assign encoder_reset = encoder_reset_reg;
    assign done_res      = done_reg;

endmodule

>>> dv/pid_line_tracer_gain_schedule_test.sv
module pid_line_tracer_gain_schedule_test
    import pidlt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IntegralWindow = 20;
    localparam int DrainCycles    = 12;
    localparam int QuietLimit     = 4000;
    localparam int PressureCycles = 150;
    localparam int IdleRare       = 31;
    localparam int IdleOften      = 85;

    localparam logic [11:0] FastLimitFirst  = 12'd2700;
    localparam logic [11:0] FastLimitSecond = 12'd1700;
    localparam logic [11:0] FastLimitThird  = 12'd550;
    localparam logic [8:0]  SlowLimitNormal = 9'd400;
    localparam logic [8:0]  SlowLimitFirst  = 9'd50;
    localparam longint      SumHigh   = 4095;
    localparam longint      SumLow    = -4096;
    localparam longint      DriveHigh = 2047;
    localparam longint      DriveLow  = -2048;

    typedef enum int {
        CFG_TYPICAL,
        CFG_MAXIMUM,
        CFG_MINIMUM,
        CFG_FULL_WIDTH
    } cfg_style_t;

    typedef struct packed {
        logic [7:0]  brightness;
        logic [15:0] distance;
    } tick_t;

    typedef struct packed {
        logic [11:0] drive_left;
        logic [11:0] drive_right;
        logic        drive_valid;
        logic        encoder_reset;
        logic        done;
    } drive_result_t;

    typedef struct packed {
        logic [7:0]  target;
        logic [6:0]  slow_speed;
        logic [6:0]  fast_speed;
        logic [13:0] kp_slow;
        logic [13:0] kd_slow;
        logic [13:0] kp_fast;
        logic [13:0] ki_fast;
        logic [13:0] kd_fast;
    } tracer_cfg_t;

    typedef struct packed {
        logic        fast_mode;
        logic [2:0]  fast_entries;
        logic [2:0]  slow_entries;
        logic [11:0] fast_limit;
        logic [8:0]  slow_limit;
        logic [12:0] error_sum;
        logic [4:0]  window_count;
        logic [8:0]  last_error;
        logic        finished;
    } tracer_state_t;

    localparam tracer_cfg_t CfgAtReset = '{
        target: 8'd40, slow_speed: 7'd35, fast_speed: 7'd70,
        kp_slow: 14'd500, kd_slow: 14'd2000, kp_fast: 14'd100,
        ki_fast: 14'd5, kd_fast: 14'd3000
    };

    localparam tracer_state_t StateAtReset = '{
        fast_mode: 1'b0, fast_entries: 3'd0, slow_entries: 3'd0,
        fast_limit: FastLimitFirst, slow_limit: SlowLimitFirst,
        error_sum: 13'd0, window_count: 5'd0, last_error: 9'd0, finished: 1'b0
    };

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           brightness = 8'd0;
    logic signed [15:0]   distance = 16'sd0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [11:0]   left_drive;
    logic signed [11:0]   right_drive;
    logic                 drive_valid;
    logic                 encoder_reset;
    logic                 done_res;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0]  cfg_data = '0;

    tick_t         queued_ticks[$];
    drive_result_t expected_drives[$];
    tracer_cfg_t   cfg_model;
    tracer_state_t model_state;
    tracer_state_t plan_state;
    int            send_idle_pct;
    int            recv_stall_pct;
    bit            pressure_on;
    bit            pressure_done;
    int            hold_left;
    int            mismatches;
    int            quiet_cycles;

    pid_line_tracer_gain_schedule #(
        .INTEGRAL_WINDOW(IntegralWindow)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .brightness   (brightness),
        .distance     (distance),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_drive   (left_drive),
        .right_drive  (right_drive),
        .drive_valid  (drive_valid),
        .encoder_reset(encoder_reset),
        .done_res     (done_res),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // One control tick: integral, mode schedule and the saturated drive.
    function automatic drive_result_t predict_tick(inout tracer_state_t st,
                                                   input tracer_cfg_t c,
                                                   input tick_t t);
        int            err;
        int            travel;
        int            sum;
        int            kp;
        int            ki;
        int            kd;
        int            speed;
        int            win;
        longint        turn;
        longint        lft;
        longint        rgt;
        logic          switched;
        drive_result_t r;
        err    = int'(t.brightness) - int'(c.target);
        travel = int'($signed(t.distance));
        kp     = st.fast_mode ? int'(c.kp_fast) : int'(c.kp_slow);
        ki     = st.fast_mode ? int'(c.ki_fast) : 0;
        kd     = st.fast_mode ? int'(c.kd_fast) : int'(c.kd_slow);
        speed  = st.fast_mode ? int'(c.fast_speed) : int'(c.slow_speed);

        sum = int'(clamp(longint'(int'($signed(st.error_sum))) + err, SumLow, SumHigh));
        st.error_sum = 13'(sum);
        turn = longint'(kp) * err / 1000 + longint'(ki) * sum / 1000
             + longint'(kd) * (err - int'($signed(st.last_error))) / 1000;
        win = int'(st.window_count) + 1;
        if (win >= IntegralWindow)
        begin
            win = 0;
            st.error_sum = '0;
        end
        st.window_count = 5'(win);

        switched = 1'b0;
        if (!st.fast_mode)
        begin
            if (travel >= int'(st.slow_limit))
            begin
                st.fast_mode = 1'b1;
                if (st.fast_entries != 3'd7)
                    st.fast_entries = st.fast_entries + 3'd1;
                if (st.fast_entries == 3'd2)
                    st.fast_limit = FastLimitSecond;
                else if (st.fast_entries == 3'd3)
                    st.fast_limit = FastLimitThird;
                else if (st.fast_entries == 3'd4)
                    st.finished = 1'b1;
                switched = 1'b1;
            end
        end
        else if (travel >= int'(st.fast_limit))
        begin
            st.fast_mode = 1'b0;
            st.slow_limit = SlowLimitNormal;
            if (st.slow_entries != 3'd7)
                st.slow_entries = st.slow_entries + 3'd1;
            if (st.slow_entries == 3'd4)
                st.slow_limit = SlowLimitFirst;
            switched = 1'b1;
        end

        lft = 0;
        rgt = 0;
        r.drive_valid = 1'b0;
        if (!switched && !st.finished)
        begin
            turn = clamp(turn, DriveLow, DriveHigh);
            lft = clamp(speed + turn, DriveLow, DriveHigh);
            rgt = clamp(speed - turn, DriveLow, DriveHigh);
            st.last_error = 9'(err);
            r.drive_valid = 1'b1;
        end
        r.drive_left    = 12'(lft);
        r.drive_right   = 12'(rgt);
        r.encoder_reset = switched;
        r.done          = st.finished;
        return r;
    endfunction

    function automatic logic [13:0] setting_value(cfg_style_t style, cfg_reg_t r);
        int in_range;
        int full;
        case (r)
            REG_BRIGHTNESS_TARGET:
            begin
                in_range = 255;
                full     = 255;
            end
            REG_SLOW_SPEED, REG_FAST_SPEED:
            begin
                in_range = 100;
                full     = 127;
            end
            default:
            begin
                in_range = 10000;
                full     = 16383;
            end
        endcase
        case (style)
            CFG_MINIMUM:    return '0;
            CFG_MAXIMUM:    return 14'(full);
            CFG_TYPICAL:    return 14'($urandom_range(in_range));
            default:        return 14'($urandom_range(16383));
        endcase
    endfunction

    // Caller is just past a rising edge; leaves cfg_valid high.
    task automatic write_register(input logic [CfgIndexW-1:0] idx,
                                  input logic [CfgDataW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk);
        while (!cfg_ready);
        case (cfg_reg_t'(idx))
            REG_BRIGHTNESS_TARGET: cfg_model.target     = value[7:0];
            REG_SLOW_SPEED:        cfg_model.slow_speed = value[6:0];
            REG_FAST_SPEED:        cfg_model.fast_speed = value[6:0];
            REG_KP_SLOW:           cfg_model.kp_slow    = value;
            REG_KD_SLOW:           cfg_model.kd_slow    = value;
            REG_KP_FAST:           cfg_model.kp_fast    = value;
            REG_KI_FAST:           cfg_model.ki_fast    = value;
            REG_KD_FAST:           cfg_model.kd_fast    = value;
            default:               ;
        endcase
    endtask

    task automatic write_settings(input cfg_style_t style);
        cfg_reg_t r;
        r = r.first();
        do
        begin
            write_register(CfgIndexW'(r), setting_value(style, r));
            r = r.next();
        end
        while (r != r.first());
        // An index past the register file must leave everything untouched.
        write_register(CfgIndexW'($urandom_range(15, int'(REG_KD_FAST) + 1)),
                       CfgDataW'($urandom_range(16383)));
        cfg_valid <= 1'b0;
    endtask

    task automatic push_tick(input logic [7:0] b, input int d);
        tick_t t;
        t.brightness = b;
        t.distance   = 16'(d);
        void'(predict_tick(plan_state, cfg_model, t));
        queued_ticks.push_back(t);
    endtask

    // Distances follow the planned mode, switching at most switch_permille per
    // thousand ticks; the course may only finish when allow_finish is set.
    task automatic queue_ticks(input int count, input int switch_permille,
                               input bit allow_finish);
        int         lim;
        int         d;
        int         bright_run;
        logic [7:0] run_level;
        logic [7:0] b;
        bit         go_switch;
        bright_run = 0;
        run_level  = '0;
        for (int n = 0; n < count; n++)
        begin
            if (bright_run == 0 && $urandom_range(99) < 4)
            begin
                bright_run = $urandom_range(40, 20);
                run_level  = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            if (bright_run > 0)
            begin
                b = run_level;
                bright_run--;
            end
            else if ($urandom_range(1))
                b = 8'($urandom_range(255));
            else
                b = 8'(clamp(int'(cfg_model.target) + int'($urandom_range(60)) - 30,
                             0, 255));

            lim = plan_state.fast_mode ? int'(plan_state.fast_limit)
                                       : int'(plan_state.slow_limit);
            go_switch = $urandom_range(999) < switch_permille
                        && (allow_finish || plan_state.fast_mode
                            || plan_state.fast_entries < 3'd3);
            if (go_switch)
            begin
                case ($urandom_range(2))
                    0:       d = lim;
                    1:       d = lim + int'($urandom_range(40));
                    default: d = int'($urandom_range(32767, lim));
                endcase
            end
            else
            begin
                case ($urandom_range(3))
                    0:       d = lim - 1;
                    1:       d = -int'($urandom_range(32768, 1));
                    default: d = int'($urandom_range(lim - 1, 0));
                endcase
            end
            push_tick(b, d);
        end
    endtask

    task automatic drain();
        do @(posedge clk);
        while (queued_ticks.size() != 0 || expected_drives.size() != 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Input driver.
    always @(posedge clk or negedge rst_n)
    begin : tick_driver
        bit    offering;
        tick_t t;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            brightness <= '0;
            distance   <= '0;
        end
        else
        begin
            offering = in_valid;
            if (in_valid && !in_stall)
            begin
                t.brightness = brightness;
                t.distance   = distance;
                expected_drives.push_back(predict_tick(model_state, cfg_model, t));
                void'(queued_ticks.pop_front());
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (queued_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid   <= 1'b1;
                    brightness <= queued_ticks[0].brightness;
                    distance   <= queued_ticks[0].distance;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and output back-pressure.
    always @(posedge clk or negedge rst_n)
    begin : drive_monitor
        drive_result_t seen;
        drive_result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = '{drive_left: left_drive, drive_right: right_drive,
                         drive_valid: drive_valid, encoder_reset: encoder_reset,
                         done: done_res};
                if (expected_drives.size() == 0)
                begin
                    $error("result beat arrived with no tick outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_drives.pop_front();
                    if (seen.drive_left !== want.drive_left)
                    begin
                        $error("left_drive: expected %0d, actual %0d",
                               $signed(want.drive_left), $signed(seen.drive_left));
                        mismatches++;
                    end
                    if (seen.drive_right !== want.drive_right)
                    begin
                        $error("right_drive: expected %0d, actual %0d",
                               $signed(want.drive_right), $signed(seen.drive_right));
                        mismatches++;
                    end
                    if (seen.drive_valid !== want.drive_valid)
                    begin
                        $error("drive_valid: expected %0d, actual %0d",
                               want.drive_valid, seen.drive_valid);
                        mismatches++;
                    end
                    if (seen.encoder_reset !== want.encoder_reset)
                    begin
                        $error("encoder_reset: expected %0d, actual %0d",
                               want.encoder_reset, seen.encoder_reset);
                        mismatches++;
                    end
                    if (seen.done !== want.done)
                    begin
                        $error("done_res: expected %0d, actual %0d",
                               want.done, seen.done);
                        mismatches++;
                    end
                end
            end
            // A long hold-off lets the pipeline fill until the input stalls.
            if (pressure_on && !pressure_done)
            begin
                hold_left     = PressureCycles;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        cfg_model      = CfgAtReset;
        model_state    = StateAtReset;
        plan_state     = StateAtReset;
        send_idle_pct  = IdleRare;
        recv_stall_pct = IdleOften;
        pressure_on    = 1'b0;
        pressure_done  = 1'b0;
        hold_left      = 0;
        mismatches     = 0;
        quiet_cycles   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed ticks at the reset settings: field extremes, entering
        // fast mode exactly at the slow limit, leaving it at full distance.
        push_tick(8'd0, -32768);
        push_tick(8'd255, 0);
        push_tick(8'd255, 49);
        push_tick(8'd40, 50);
        push_tick(8'd0, 2699);
        push_tick(8'd255, -1);
        push_tick(8'd128, 32767);
        push_tick(8'd255, 399);
        push_tick(8'd0, 0);
        push_tick(8'd1, -2);
        drain();

        write_settings(CFG_TYPICAL);
        queue_ticks(240, 4, 1'b0);
        drain();
        write_settings(CFG_MAXIMUM);
        queue_ticks(240, 4, 1'b0);
        drain();

        send_idle_pct  = IdleOften;
        recv_stall_pct = IdleRare;
        write_settings(CFG_TYPICAL);
        queue_ticks(240, 4, 1'b0);
        drain();
        write_settings(CFG_MINIMUM);
        queue_ticks(240, 4, 1'b0);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_settings(CFG_FULL_WIDTH);
        queue_ticks(240, 4, 1'b0);
        pressure_on = 1'b1;
        drain();

        // Frequent switches: the course finishes and both entry counters
        // run into saturation.
        write_settings(CFG_TYPICAL);
        queue_ticks(250, 100, 1'b1);
        drain();

        if (mismatches == 0 && expected_drives.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
